[src/vcs_pkg.sv]
// Shared types and constants for the vector cosine similarity unit.
package vcs_pkg;

    localparam int SUM_BITS        = 44;
    localparam int ROOT_BITS       = SUM_BITS / 2;
    localparam int QUO_BITS        = SUM_BITS + 15;
    localparam int OUT_BITS        = 16;
    localparam int ELEM_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Finished sums of one vector pair, handed from front to back.
    typedef struct packed {
        logic signed [SUM_BITS-1:0] dot;
        logic [SUM_BITS-1:0]        norm_a;
        logic [SUM_BITS-1:0]        norm_b;
    } job_t;

endpackage

[src/vcs_front.sv]
// Front end: element products and saturating dot / norm accumulators.
module vcs_front import vcs_pkg::*;
#(
    parameter int ELEM_BITS   = ELEM_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] elem_a,
    input  logic signed [15:0] elem_b,
    input  logic               last,
    input  logic [CNT_W-1:0]   q_count,
    output logic               job_push,
    output job_t               job
);

    localparam int EXT_W  = (ELEM_BITS > 16) ? ELEM_BITS : 16;
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int ACC_W  = ((PROD_W > SUM_BITS) ? PROD_W : SUM_BITS) + 1;

    logic [EXT_W-1:0]           ext_a;
    logic [EXT_W-1:0]           ext_b;
    logic signed [ELEM_BITS-1:0] val_a;
    logic signed [ELEM_BITS-1:0] val_b;
    logic signed [PROD_W-1:0]   prod_ab;
    logic signed [PROD_W-1:0]   prod_aa;
    logic signed [PROD_W-1:0]   prod_bb;

    logic signed [PROD_W-1:0]   prod_ab_reg;
    logic [PROD_W-1:0]          sq_a_reg;
    logic [PROD_W-1:0]          sq_b_reg;
    logic                       p_valid_reg;
    logic                       p_last_reg;

    logic signed [SUM_BITS-1:0] dot_reg;
    logic [SUM_BITS-1:0]        na_reg;
    logic [SUM_BITS-1:0]        nb_reg;

    logic signed [ACC_W-1:0]    dot_wide;
    logic [ACC_W-1:0]           na_wide;
    logic [ACC_W-1:0]           nb_wide;
    logic [ACC_W-SUM_BITS:0]    dot_top;
    logic signed [SUM_BITS-1:0] dot_sat;
    logic [SUM_BITS-1:0]        na_sat;
    logic [SUM_BITS-1:0]        nb_sat;
    logic                       accept;
    logic [CNT_W:0]             q_load;

    // Low ELEM_BITS of the zero-extended field, read as two's complement.
    assign ext_a = EXT_W'($unsigned(elem_a));
    assign ext_b = EXT_W'($unsigned(elem_b));
    assign val_a = signed'(ext_a[ELEM_BITS-1:0]);
    assign val_b = signed'(ext_b[ELEM_BITS-1:0]);

    assign prod_ab = val_a * val_b;
    assign prod_aa = val_a * val_a;
    assign prod_bb = val_b * val_b;

    // A pending last in the product stage still needs a queue slot.
    assign q_load = {1'b0, q_count} + (CNT_W+1)'(p_valid_reg & p_last_reg);
    assign full   = q_load >= (CNT_W+1)'(QUEUE_DEPTH);
    assign accept = push & ~full;

    assign dot_wide = ACC_W'(dot_reg) + ACC_W'(prod_ab_reg);
    assign na_wide  = ACC_W'(na_reg) + ACC_W'(sq_a_reg);
    assign nb_wide  = ACC_W'(nb_reg) + ACC_W'(sq_b_reg);
    assign dot_top  = dot_wide[ACC_W-1:SUM_BITS-1];

    always_comb
    begin
        if (dot_top == '0 || dot_top == '1)
        begin
            dot_sat = dot_wide[SUM_BITS-1:0];
        end
        else if (dot_wide[ACC_W-1])
        begin
            dot_sat = {1'b1, {(SUM_BITS-1){1'b0}}};
        end
        else
        begin
            dot_sat = {1'b0, {(SUM_BITS-1){1'b1}}};
        end
        na_sat = (|na_wide[ACC_W-1:SUM_BITS]) ? '1 : na_wide[SUM_BITS-1:0];
        nb_sat = (|nb_wide[ACC_W-1:SUM_BITS]) ? '1 : nb_wide[SUM_BITS-1:0];
    end

    assign job_push    = p_valid_reg & p_last_reg;
    assign job.dot     = dot_sat;
    assign job.norm_a  = na_sat;
    assign job.norm_b  = nb_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            dot_reg     <= '0;
            na_reg      <= '0;
            nb_reg      <= '0;
        end
        else
        begin
            p_valid_reg <= accept;
            p_last_reg  <= last;
            if (p_valid_reg)
            begin
                if (p_last_reg)
                begin
                    dot_reg <= '0;
                    na_reg  <= '0;
                    nb_reg  <= '0;
                end
                else
                begin
                    dot_reg <= dot_sat;
                    na_reg  <= na_sat;
                    nb_reg  <= nb_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_ab_reg <= prod_ab;
            sq_a_reg    <= $unsigned(prod_aa);
            sq_b_reg    <= $unsigned(prod_bb);
        end
    end

endmodule

[src/vcs_fifo.sv]
// Short queue of finished vector sums between front and back.
module vcs_fifo import vcs_pkg::*;
#(
    parameter int DEPTH  = QUEUE_DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int PTR_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  job_t             wr_data,
    input  logic             rd_en,
    output job_t             rd_data,
    output logic [CNT_W-1:0] count
);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign count   = count_reg;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/vcs_back.sv]
// Back end: two floor square roots, denominator multiply, restoring divide.
module vcs_back import vcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [CNT_W-1:0]           q_count,
    input  job_t                       q_data,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [OUT_BITS-1:0] cosine,
    output logic                       zero_norm
);

    localparam int STEP_W = $clog2(QUO_BITS);

    typedef enum logic [2:0] {ST_IDLE, ST_ROOT, ST_MUL, ST_DIV, ST_DONE} state_t;

    state_t                state_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [SUM_BITS-1:0]   xa_reg;
    logic [SUM_BITS-1:0]   xb_reg;
    logic [SUM_BITS-1:0]   ra_reg;
    logic [SUM_BITS-1:0]   rb_reg;
    logic [SUM_BITS-1:0]   probe_reg;
    logic                  neg_reg;
    logic [SUM_BITS-1:0]   denom_reg;
    logic [SUM_BITS:0]     rem_reg;
    logic [QUO_BITS-1:0]   nq_reg;
    logic                  res_valid_reg;
    logic [OUT_BITS-1:0]   cosine_reg;
    logic                  zero_norm_reg;

    logic [SUM_BITS-1:0]   ta;
    logic [SUM_BITS-1:0]   tb;
    logic                  ge_a;
    logic                  ge_b;
    logic [SUM_BITS-1:0]   dot_mag;
    logic [SUM_BITS:0]     shifted;
    logic                  ge_d;
    logic [OUT_BITS-1:0]   cos_val;
    logic                  out_free;

    assign q_pop     = (state_reg == ST_IDLE) && (q_count != '0);
    assign empty     = ~res_valid_reg;
    assign cosine    = signed'(cosine_reg);
    assign zero_norm = zero_norm_reg;
    assign out_free  = ~res_valid_reg | pop;

    always_comb
    begin
        ta      = ra_reg + probe_reg;
        tb      = rb_reg + probe_reg;
        ge_a    = xa_reg >= ta;
        ge_b    = xb_reg >= tb;
        dot_mag = q_data.dot[SUM_BITS-1] ? $unsigned(-q_data.dot) : $unsigned(q_data.dot);
        shifted = {rem_reg[SUM_BITS-1:0], nq_reg[QUO_BITS-1]};
        ge_d    = shifted >= {1'b0, denom_reg};
        if (denom_reg == '0)
        begin
            cos_val = '0;
        end
        else if (!neg_reg)
        begin
            cos_val = (nq_reg > QUO_BITS'(32767)) ? 16'h7fff : nq_reg[OUT_BITS-1:0];
        end
        else
        begin
            cos_val = (nq_reg > QUO_BITS'(32768)) ? 16'h8000 : -nq_reg[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            xa_reg        <= '0;
            xb_reg        <= '0;
            ra_reg        <= '0;
            rb_reg        <= '0;
            probe_reg     <= '0;
            neg_reg       <= 1'b0;
            denom_reg     <= '0;
            rem_reg       <= '0;
            nq_reg        <= '0;
            res_valid_reg <= 1'b0;
            cosine_reg    <= '0;
            zero_norm_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        xa_reg    <= q_data.norm_a;
                        xb_reg    <= q_data.norm_b;
                        ra_reg    <= '0;
                        rb_reg    <= '0;
                        probe_reg <= SUM_BITS'(1) << (SUM_BITS - 2);
                        neg_reg   <= q_data.dot[SUM_BITS-1];
                        nq_reg    <= {dot_mag, 15'b0};
                        step_reg  <= STEP_W'(ROOT_BITS - 1);
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    // One result bit per cycle for both roots.
                    if (ge_a)
                    begin
                        xa_reg <= xa_reg - ta;
                        ra_reg <= (ra_reg >> 1) + probe_reg;
                    end
                    else
                    begin
                        ra_reg <= ra_reg >> 1;
                    end
                    if (ge_b)
                    begin
                        xb_reg <= xb_reg - tb;
                        rb_reg <= (rb_reg >> 1) + probe_reg;
                    end
                    else
                    begin
                        rb_reg <= rb_reg >> 1;
                    end
                    probe_reg <= probe_reg >> 2;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                ST_MUL:
                begin
                    denom_reg <= SUM_BITS'(ra_reg[ROOT_BITS-1:0] * rb_reg[ROOT_BITS-1:0]);
                    rem_reg   <= '0;
                    step_reg  <= STEP_W'(QUO_BITS - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // Zero denominator runs through harmlessly; flagged at the end.
                    rem_reg <= ge_d ? shifted - {1'b0, denom_reg} : shifted;
                    nq_reg  <= {nq_reg[QUO_BITS-2:0], ge_d};
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        cosine_reg    <= cos_val;
                        zero_norm_reg <= (denom_reg == '0);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[src/vector_cosine_similarity_unit.sv]
// Top level of the streaming cosine similarity unit.
//
//  channel   direction  transfer when       payload
//  input     in         push & !full        elem_a, elem_b, last
//  result    out        pop & !empty        cosine, zero_norm
//
// Element pairs transfer one per cycle while full is low; products register,
// then accumulate. A pair marked last hands its sums to a QUEUE_DEPTH entry
// queue; the back end does 22 root steps, one multiply, 59 divide steps each.
// full rises only when the queue has no slot left for another finished vector.
// A waiting result holds on the result ports until popped; rst_n clears all
// control state and the sums, asynchronously.
module vector_cosine_similarity_unit import vcs_pkg::*;
#(
    parameter int ELEM_BITS   = ELEM_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [15:0]         elem_a,
    input  logic signed [15:0]         elem_b,
    input  logic                       last,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [OUT_BITS-1:0] cosine,
    output logic                       zero_norm
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             job_push;
    job_t             job_in;
    job_t             job_out;
    logic             job_pop;
    logic [CNT_W-1:0] q_count;

    vcs_front #(
        .ELEM_BITS   (ELEM_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .elem_a   (elem_a),
        .elem_b   (elem_b),
        .last     (last),
        .q_count  (q_count),
        .job_push (job_push),
        .job      (job_in)
    );

    vcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .count   (q_count)
    );

    vcs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_count   (q_count),
        .q_data    (job_out),
        .q_pop     (job_pop),
        .empty     (empty),
        .pop       (pop),
        .cosine    (cosine),
        .zero_norm (zero_norm)
    );

endmodule

[src/vcs_checker.sv]
// Port-level checks for the cosine similarity unit, bound to the top level.
module vcs_checker import vcs_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       push,
    input logic                       full,
    input logic signed [15:0]         elem_a,
    input logic signed [15:0]         elem_b,
    input logic                       last,
    input logic                       empty,
    input logic                       pop,
    input logic signed [OUT_BITS-1:0] cosine,
    input logic                       zero_norm
);

    logic in_xfer_last;

    assign in_xfer_last = push && !full && last && (elem_a == elem_a) && (elem_b == elem_b);

    // A zero norm result always carries a zero cosine.
    a_zero_norm_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && zero_norm) |-> (cosine == '0))
        else $error("zero_norm result with nonzero cosine");

    // A waiting result stays put until it transfers.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(cosine) && $stable(zero_norm)))
        else $error("waiting result changed before transfer");

    // Nothing waits on the result side right out of reset.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result present right after reset");

    // Back pressure only builds up behind a finished vector.
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> ($past(in_xfer_last) || $past(in_xfer_last, 2)))
        else $error("full rose with no recent last transfer");

endmodule

bind vector_cosine_similarity_unit vcs_checker u_vcs_checker (.*);

[verif/testbench.sv]
// Self-checking testbench for the vector cosine similarity unit.
`timescale 1ns / 1ps

module testbench;
    import vcs_pkg::*;

    localparam longint          DOT_HI  = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint          DOT_LO  = -DOT_HI - 1;
    localparam longint unsigned NORM_HI = (64'd1 << SUM_BITS) - 1;
    localparam logic signed [15:0] E_MIN = 16'sh8000;
    localparam logic signed [15:0] E_MAX = 16'sh7FFF;

    typedef enum int {
        MIX_RANDOM,
        MIX_SMALL,
        MIX_SAME,
        MIX_NEGATED,
        MIX_NEAR,
        MIX_ZERO_A,
        MIX_EXTREME
    } mix_t;

    class cosine_scoreboard;
        typedef struct {
            logic signed [15:0] cos;
            logic               zn;
        } cos_result_t;

        longint          dot_acc;
        longint unsigned norm_a_acc;
        longint unsigned norm_b_acc;
        cos_result_t     expected_cos[$];
        int              errors;
        int              pairs;
        int              results;
        int              zero_hits;
        int              clipped;

        function new();
            dot_acc    = 0;
            norm_a_acc = 0;
            norm_b_acc = 0;
            errors     = 0;
            pairs      = 0;
            results    = 0;
            zero_hits  = 0;
            clipped    = 0;
        endfunction

        // Bitwise floor root; sums stay below 2^44, so the root fits 22 bits.
        function longint unsigned floor_root(longint unsigned x);
            longint unsigned root;
            longint unsigned probe;
            root = 0;
            for (int k = 22; k >= 0; k--)
            begin
                probe = root | (64'd1 << k);
                if (probe * probe <= x)
                    root = probe;
            end
            return root;
        endfunction

        function void note_pair(logic signed [15:0] a, logic signed [15:0] b, logic lst);
            longint          ea;
            longint          eb;
            longint          q;
            longint unsigned den;
            cos_result_t     r;
            ea = a;
            eb = b;
            pairs++;
            dot_acc = dot_acc + ea * eb;
            if (dot_acc > DOT_HI)
                dot_acc = DOT_HI;
            if (dot_acc < DOT_LO)
                dot_acc = DOT_LO;
            norm_a_acc = norm_a_acc + longint'(ea * ea);
            if (norm_a_acc > NORM_HI)
                norm_a_acc = NORM_HI;
            norm_b_acc = norm_b_acc + longint'(eb * eb);
            if (norm_b_acc > NORM_HI)
                norm_b_acc = NORM_HI;
            if (!lst)
                return;
            den = floor_root(norm_a_acc) * floor_root(norm_b_acc);
            if (den == 0)
            begin
                r.cos = '0;
                r.zn  = 1'b1;
                zero_hits++;
            end
            else
            begin
                q = (dot_acc * 32768) / longint'(den);
                if (q > 32767 || q < -32768)
                    clipped++;
                if (q > 32767)
                    q = 32767;
                if (q < -32768)
                    q = -32768;
                r.cos = q[15:0];
                r.zn  = 1'b0;
            end
            expected_cos.push_back(r);
            dot_acc    = 0;
            norm_a_acc = 0;
            norm_b_acc = 0;
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic signed [15:0] cos, logic zn);
            cos_result_t r;
            if (expected_cos.size() == 0)
            begin
                report($sformatf("unexpected result cosine=%0d zero_norm=%0b", cos, zn));
                return;
            end
            r = expected_cos.pop_front();
            results++;
            if (cos !== r.cos)
                report($sformatf("result %0d cosine=%0d, want %0d", results, cos, r.cos));
            if (zn !== r.zn)
                report($sformatf("result %0d zero_norm=%0b, want %0b", results, zn, r.zn));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last;
    logic               empty;
    logic               pop;
    logic signed [15:0] cosine;
    logic               zero_norm;

    cosine_scoreboard sb;
    bit               quiet = 1'b0;

    vector_cosine_similarity_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .last      (last),
        .empty     (empty),
        .pop       (pop),
        .cosine    (cosine),
        .zero_norm (zero_norm)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", sb.expected_cos.size());
        $display("FAIL vector_cosine_similarity_unit");
        $finish;
    end

    // Occasional stretches where neither side idles.
    initial
    begin
        forever
        begin
            repeat ($urandom_range(200, 800)) @(posedge clk);
            quiet <= ($urandom_range(0, 3) == 0);
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
    endfunction

    function automatic logic signed [15:0] edge_value();
        case ($urandom_range(0, 4))
            0: return E_MIN;
            1: return E_MAX;
            2: return 16'sd0;
            3: return 16'sd1;
            default: return -16'sd1;
        endcase
    endfunction

    task automatic idle_push(int n);
        @(negedge clk);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic lst);
        @(negedge clk);
        push   <= 1'b1;
        elem_a <= a;
        elem_b <= b;
        last   <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_pair(a, b, lst);
    endtask

    // Result side: pop with random stalls, check every transfer.
    initial
    begin
        int hold;
        hold = 0;
        pop  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else
            begin
                pop <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    hold = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(cosine, zero_norm);
    end

    initial
    begin
        int                 items;
        int                 len;
        int                 sel;
        int                 near;
        mix_t               mix;
        logic signed [15:0] a;
        logic signed [15:0] b;

        sb      = new();
        items   = 0;
        push    = 1'b0;
        elem_a  = '0;
        elem_b  = '0;
        last    = 1'b0;
        rst_n   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single pairs at the extremes: ratio of one clips to full scale
        send_pair(E_MAX, E_MAX, 1'b1);
        send_pair(E_MIN, E_MIN, 1'b1);
        send_pair(E_MIN, E_MAX, 1'b1);
        // zero norm on either side or both
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(16'sd7, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        // orthogonal
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        // floored roots push |dot| above denom
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, 16'sd1, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b1);
        // negative quotient truncates toward zero
        send_pair(16'sd3, -16'sd5, 1'b0);
        send_pair(-16'sd4, 16'sd2, 1'b1);
        send_pair(16'sd1, 16'sd4, 1'b0);
        send_pair(16'sd2, 16'sd5, 1'b0);
        send_pair(16'sd3, 16'sd6, 1'b1);
        send_pair(16'sh5555, 16'shAAAA, 1'b0);
        send_pair(16'shAAAA, 16'sh5555, 1'b1);

        while (items < 1200)
        begin
            sel = $urandom_range(0, 99);
            len = (sel < 70) ? $urandom_range(1, 8)
                : (sel < 95) ? $urandom_range(9, 64) : $urandom_range(65, 400);
            if (len > 1200 - items)
                len = 1200 - items;
            mix = mix_t'($urandom_range(0, 6));
            for (int i = 0; i < len; i++)
            begin
                a = 16'($urandom);
                b = 16'($urandom);
                case (mix)
                    MIX_SMALL:
                    begin
                        a = 16'($urandom_range(0, 16)) - 16'sd8;
                        b = 16'($urandom_range(0, 16)) - 16'sd8;
                    end
                    MIX_SAME:    b = a;
                    MIX_NEGATED: b = -a;
                    MIX_NEAR:
                    begin
                        near = a + $urandom_range(0, 64) - 32;
                        b = 16'(near);
                    end
                    MIX_ZERO_A:
                    begin
                        a = '0;
                        if ($urandom_range(0, 3) == 0)
                            b = '0;
                    end
                    MIX_EXTREME:
                    begin
                        a = edge_value();
                        b = edge_value();
                    end
                    default: ;
                endcase
                if (!quiet && $urandom_range(0, 3) == 0)
                    idle_push(gap_len());
                send_pair(a, b, i == len - 1);
            end
            items += len;
        end
        idle_push(1);

        while (sb.expected_cos.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("ran %0d element pairs, %0d results checked", sb.pairs, sb.results);
        $display("%0d zero-norm results, %0d clipped to full scale", sb.zero_hits, sb.clipped);
        if (sb.errors == 0)
            $display("PASS vector_cosine_similarity_unit");
        else
            $display("FAIL vector_cosine_similarity_unit");
        $finish;
    end

endmodule
